FILE: design/depth_map_clamp_subsample_defines.svh
// ----------------------------------------------------------------------------
// Depth map clamp and subsample: assertion macros
// Shared macros for the concurrent checks of the depth map block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_MAP_CLAMP_SUBSAMPLE_DEFINES_SVH
`define DEPTH_MAP_CLAMP_SUBSAMPLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmcs check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmcs check failed");

`endif

FILE: design/dmcs_pkg.sv
// ----------------------------------------------------------------------------
// Depth map clamp and subsample: package
// Field widths, register indexes, reset values and the map entry type.
// ----------------------------------------------------------------------------
package dmcs_pkg;

   localparam int COORD_W     = 16;
   localparam int DEPTH_W     = 15;
   localparam int INDEX_W     = 20;
   localparam int COUNT_W     = 20;
   localparam int GEOM_W      = 11;
   localparam int ROW_W       = 10;
   localparam int MAX_HEIGHT  = 1024;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [GEOM_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [GEOM_W-1:0]  HEIGHT_RESET = 11'd480;
   localparam logic [DEPTH_W-1:0] LIMIT_RESET  = 15'd10000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_DEPTH_LIMIT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DEPTH_W-1:0] depth;
   } map_entry_type;

endpackage

FILE: design/dmcs_line_store.sv
// ----------------------------------------------------------------------------
// Depth map clamp and subsample: line store
// Half-width store of sampled map entries with a registered, write-first read.
// ----------------------------------------------------------------------------
module dmcs_line_store
   import dmcs_pkg::*;
#(
   parameter int ADDR_W = 9
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  map_entry_type        wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output map_entry_type        rd_data
);

   map_entry_type mem [2**ADDR_W];
   map_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/depth_map_clamp_subsample.sv
// ----------------------------------------------------------------------------
// Depth map clamp and subsample: top level
// Turns a raster stream of point-cloud pixels into clamped depth-map pixels,
// with per-frame depth statistics and 2x2 block subsampling for wide frames.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and returns one result beat per
// pixel, in order: the pixel is captured in an input register together with
// its column and row, and the clamp, the raster index multiply, the block
// copy and the statistics update finish in one pass into the result register.
// The line store has one write and one read port; its read is issued as the
// pixel is accepted, so its entry is ready by the time the pixel is worked.
// Sustained rate is one pixel per cycle whenever the result side does not
// stall. Line store entries are not cleared; each is written on an even row
// before the odd row reads it, so no clearing pass follows reset.
`include "depth_map_clamp_subsample_defines.svh"

module depth_map_clamp_subsample
   import dmcs_pkg::*;
#(
   parameter int MAX_WIDTH      = 1024,
   parameter int WIDE_THRESHOLD = 320
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_W-1:0]     req_point_x,
   input  logic signed [COORD_W-1:0]     req_point_y,
   input  logic signed [COORD_W-1:0]     req_point_z,
   input  logic                          req_is_finite,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_W-1:0]     rsp_map_x,
   output logic signed [COORD_W-1:0]     rsp_map_y,
   output logic [DEPTH_W-1:0]            rsp_map_depth,
   output logic [INDEX_W-1:0]            rsp_pixel_index,
   output logic                          rsp_is_valid,
   output logic [COUNT_W-1:0]            rsp_valid_count,
   output logic [DEPTH_W-1:0]            rsp_depth_min,
   output logic [DEPTH_W-1:0]            rsp_depth_max,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int W_W     = $clog2(MAX_WIDTH + 1);
   localparam int SAT_W   = (W_W > GEOM_W) ? W_W : GEOM_W;
   localparam int LS_AW   = COL_W - 1;
   localparam int PROD_W  = ROW_W + W_W;
   localparam int SUM_W   = (PROD_W + 1 > INDEX_W) ? PROD_W + 1 : INDEX_W;
   localparam logic [31:0] WIDE_LIM = WIDE_THRESHOLD;

   // Configuration registers.
   logic [GEOM_W-1:0]  cfg_width_ff;
   logic [GEOM_W-1:0]  cfg_height_ff;
   logic [DEPTH_W-1:0] cfg_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
         cfg_limit_ff  <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               cfg_width_ff <= csr_data[GEOM_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               cfg_height_ff <= csr_data[GEOM_W-1:0];
            end
            CSR_DEPTH_LIMIT: begin
               cfg_limit_ff <= csr_data[DEPTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Saturated frame geometry.
   logic [SAT_W-1:0]  width_ext;
   logic [SAT_W-1:0]  width_full;
   logic [W_W-1:0]    width_sat;
   logic [GEOM_W-1:0] height_sat;
   logic              wide_mode;

   assign width_ext = SAT_W'(cfg_width_ff);

   always_comb begin
      if (width_ext < SAT_W'(2)) begin
         width_full = SAT_W'(2);
      end else if (width_ext > SAT_W'(MAX_WIDTH)) begin
         width_full = SAT_W'(MAX_WIDTH);
      end else begin
         width_full = width_ext;
      end
      if (cfg_height_ff < GEOM_W'(2)) begin
         height_sat = GEOM_W'(2);
      end else if (cfg_height_ff > GEOM_W'(MAX_HEIGHT)) begin
         height_sat = GEOM_W'(MAX_HEIGHT);
      end else begin
         height_sat = cfg_height_ff;
      end
   end

   assign width_sat = width_full[W_W-1:0];
   assign wide_mode = 32'(width_sat) > WIDE_LIM;

   // Flow control.
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic accept;
   logic compute;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign compute   = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (compute) begin
            s1_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= compute || (rsp_valid_ff && rsp_stall);
      end
   end

   // Raster position, advanced as each beat is accepted.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_col_in;
   logic             last_in;

   assign last_col_in = (W_W'(col_ff) + W_W'(1)) >= width_sat;
   assign last_in     = last_col_in && ((GEOM_W'(row_ff) + GEOM_W'(1)) >= height_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_in) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (last_col_in) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Input register.
   logic [COORD_W-1:0] s1_x_ff;
   logic [COORD_W-1:0] s1_y_ff;
   logic [COORD_W-1:0] s1_z_ff;
   logic               s1_finite_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff      <= req_point_x;
         s1_y_ff      <= req_point_y;
         s1_z_ff      <= req_point_z;
         s1_finite_ff <= req_is_finite;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_last_ff   <= last_in;
      end
   end

   // Line store.
   logic          ls_wr_en;
   logic          ls_wr_sel;
   map_entry_type ls_rd_data;
   map_entry_type mapped;

   assign ls_wr_en = ls_wr_sel && compute;

   dmcs_line_store #(
      .ADDR_W (LS_AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (s1_col_ff[COL_W-1:1]),
      .wr_data (mapped),
      .rd_en   (accept),
      .rd_addr (col_ff[COL_W-1:1]),
      .rd_data (ls_rd_data)
   );

   // Single-pass pixel work.
   logic [SUM_W-1:0]   index_full;
   logic               pix_valid;
   logic [COORD_W-1:0] z_mag;
   logic [DEPTH_W-1:0] depth;
   logic               even_site;
   logic               sample;
   map_entry_type      entry_new;
   map_entry_type      hold_ff;
   map_entry_type      hold_in;
   logic [DEPTH_W-1:0] run_min_ff;
   logic [DEPTH_W-1:0] run_max_ff;
   logic [COUNT_W-1:0] valid_total_ff;
   logic [DEPTH_W-1:0] run_min_in;
   logic [DEPTH_W-1:0] run_max_in;
   logic [COUNT_W-1:0] valid_total_in;

   assign index_full = SUM_W'(s1_row_ff) * SUM_W'(width_sat) + SUM_W'(s1_col_ff);
   assign pix_valid  = s1_finite_ff && (index_full != '0);
   assign z_mag      = s1_z_ff[COORD_W-1] ? (~s1_z_ff + COORD_W'(1)) : s1_z_ff;
   assign depth      = (z_mag > COORD_W'(cfg_limit_ff)) ? cfg_limit_ff : z_mag[DEPTH_W-1:0];
   assign even_site  = !s1_row_ff[0] && !s1_col_ff[0];
   assign entry_new  = '{x: s1_x_ff, y: s1_y_ff, depth: depth};

   always_comb begin
      sample    = pix_valid;
      mapped    = '0;
      hold_in   = hold_ff;
      ls_wr_sel = 1'b0;
      if (!wide_mode) begin
         if (pix_valid) begin
            mapped = entry_new;
         end
      end else begin
         sample = pix_valid && even_site;
         priority if (even_site) begin
            mapped    = sample ? entry_new : '0;
            hold_in   = mapped;
            ls_wr_sel = 1'b1;
         end else if (!s1_row_ff[0]) begin
            mapped = hold_ff;
         end else begin
            mapped = ls_rd_data;
         end
      end
   end

   assign run_min_in     = (sample && (depth < run_min_ff)) ? depth : run_min_ff;
   assign run_max_in     = (sample && (depth > run_max_ff)) ? depth : run_max_ff;
   assign valid_total_in = pix_valid ? (valid_total_ff + COUNT_W'(1)) : valid_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff     <= '1;
         run_max_ff     <= '0;
         valid_total_ff <= '0;
         hold_ff        <= '0;
      end else if (compute) begin
         hold_ff <= hold_in;
         if (s1_last_ff) begin
            run_min_ff     <= '1;
            run_max_ff     <= '0;
            valid_total_ff <= '0;
         end else begin
            run_min_ff     <= run_min_in;
            run_max_ff     <= run_max_in;
            valid_total_ff <= valid_total_in;
         end
      end
   end

   // Result register.
   map_entry_type      rsp_map_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_is_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [DEPTH_W-1:0] rsp_min_ff;
   logic [DEPTH_W-1:0] rsp_max_ff;
   logic               rsp_end_ff;

   always_ff @(posedge clock) begin
      if (compute) begin
         rsp_map_ff      <= mapped;
         rsp_index_ff    <= index_full[INDEX_W-1:0];
         rsp_is_valid_ff <= pix_valid;
         rsp_count_ff    <= valid_total_in;
         rsp_min_ff      <= run_min_in;
         rsp_max_ff      <= run_max_in;
         rsp_end_ff      <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_map_x       = rsp_map_ff.x;
   assign rsp_map_y       = rsp_map_ff.y;
   assign rsp_map_depth   = rsp_map_ff.depth;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_is_valid    = rsp_is_valid_ff;
   assign rsp_valid_count = rsp_count_ff;
   assign rsp_depth_min   = rsp_min_ff;
   assign rsp_depth_max   = rsp_max_ff;
   assign rsp_frame_end   = rsp_end_ff;

   // A valid pixel always has a non-zero count in its beat.
   `DMCS_ASSERT_SAME(a_valid_counted, clock, reset, rsp_valid && rsp_is_valid, rsp_valid_count != '0)
   // The raster position restarts after the last pixel of a frame is accepted.
   `DMCS_ASSERT_NEXT(a_position_restart, clock, reset, accept && last_in, col_ff == '0 && row_ff == '0)
   // Frame statistics restart once the last pixel has been worked.
   `DMCS_ASSERT_NEXT(a_stats_restart, clock, reset, compute && s1_last_ff, run_max_ff == '0 && valid_total_ff == '0)

endmodule
